>>> src/lcsr_pkg.sv
// ----------------------------------------------------------------------------
// lcsr_pkg
// Shared types and constants of the LED command and switch reporter.
// ----------------------------------------------------------------------------
package lcsr_pkg;

  // Input item kinds.
  localparam logic [1:0] CMD_HOST = 2'd0;
  localparam logic [1:0] CMD_SCAN = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // ASCII codes of the host protocol.
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_W     = 8'h57;
  localparam logic [7:0] CHAR_Y     = 8'h59;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_A_UP  = 8'h41;
  localparam logic [7:0] CHAR_H_UP  = 8'h48;
  localparam logic [7:0] CHAR_A_LOW = 8'h61;
  localparam logic [7:0] CHAR_H_LOW = 8'h68;
  localparam logic [7:0] CHAR_U_UP  = 8'h55;
  localparam logic [7:0] CHAR_U_LOW = 8'h75;

  localparam logic [12:0] RESEND_MASK = 13'h7FF;
  localparam logic [7:0]  DIGIT_RESET = 8'h40;

  // Source of the reply byte loaded into the output register.
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_W,
    SRC_Y,
    SRC_LETTER,
    SRC_LEVEL
  } src_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NONE,
    ST_W,
    ST_Y,
    ST_LETTER,
    ST_LEVEL
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    src_t sel;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_connect;
    logic has_changes;
    logic more_changes;
  } dp_status_t;

  // Letter that names a changed switch bit.
  function automatic logic [7:0] change_letter(input logic [3:0] idx);
    logic [7:0] letter;
    case (idx)
      4'd11:   letter = 8'h71;
      4'd12:   letter = 8'h72;
      default: letter = 8'h49 + {4'd0, idx};
    endcase
    return letter;
  endfunction

endpackage

>>> src/led_command_switch_reporter_core.sv
// ----------------------------------------------------------------------------
// led_command_switch_reporter_core
// Host command interpreter for a digit and LED panel with switch reporting.
// ----------------------------------------------------------------------------
// The slave stream carries one item per transfer: a host command byte, a
// switch scan or a display multiplex tick, with the item kind on tuser. The
// master stream returns the results of each item in order, one reply byte
// per transfer, with tlast on the final result of the item and tuser set
// when the byte is to be sent. Every result also shows the driven digit's
// segments, its one-hot enable and the LED word.
// The first result is loaded into the output register from the state that
// follows the accepting idle state. An item with no reply gives a single
// result, a connect two and a scan with k changed bits 2k; the reply
// sequencer emits one byte per cycle while the receiver is ready and holds
// the input until the last result of the item is in the output register.
// Reset clears the link, the word pointer, the scan position and the last
// switch image, and returns the digit words to 0x40 and the LED word to 0.
// A stalled receiver holds the output register; the sequencer waits and
// no result is lost.
// ----------------------------------------------------------------------------
module led_command_switch_reporter_core #(
  parameter int NUM_SWITCHES = 13,
  parameter int NUM_DIGITS   = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // host_byte[7:0], switches[20:8]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // reply_byte[7:0], segment_pattern[15:8],
                                 // digit_enable[19:16], led_pattern[27:20]
  output logic        m_tuser,   // reply_valid[0]
  output logic        m_tlast    // run_last
);

  lcsr_pkg::ctrl_cmd_t  cmd;
  lcsr_pkg::dp_status_t status;

  lcsr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lcsr_datapath #(
    .NUM_SWITCHES (NUM_SWITCHES),
    .NUM_DIGITS   (NUM_DIGITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

>>> src/lcsr_ctrl.sv
// ----------------------------------------------------------------------------
// lcsr_ctrl
// Sequencer that takes one item at a time and steps through its reply bytes.
// ----------------------------------------------------------------------------
module lcsr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  input  lcsr_pkg::dp_status_t   status,
  output lcsr_pkg::ctrl_cmd_t    cmd
);

  lcsr_pkg::state_t state, state_next;
  logic can_load;

  assign can_load = !m_tvalid || m_tready;
  assign s_tready = (state == lcsr_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lcsr_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd.accept = 1'b0;
    cmd.load   = 1'b0;
    cmd.sel    = lcsr_pkg::SRC_NONE;
    cmd.last   = 1'b0;
    case (state)
      lcsr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.is_connect) begin
            state_next = lcsr_pkg::ST_W;
          end else if (status.has_changes) begin
            state_next = lcsr_pkg::ST_LETTER;
          end else begin
            state_next = lcsr_pkg::ST_NONE;
          end
        end
      end
      lcsr_pkg::ST_NONE: begin
        cmd.sel  = lcsr_pkg::SRC_NONE;
        cmd.last = 1'b1;
        if (can_load) begin
          cmd.load   = 1'b1;
          state_next = lcsr_pkg::ST_IDLE;
        end
      end
      lcsr_pkg::ST_W: begin
        cmd.sel = lcsr_pkg::SRC_W;
        if (can_load) begin
          cmd.load   = 1'b1;
          state_next = lcsr_pkg::ST_Y;
        end
      end
      lcsr_pkg::ST_Y: begin
        cmd.sel  = lcsr_pkg::SRC_Y;
        cmd.last = 1'b1;
        if (can_load) begin
          cmd.load   = 1'b1;
          state_next = lcsr_pkg::ST_IDLE;
        end
      end
      lcsr_pkg::ST_LETTER: begin
        cmd.sel = lcsr_pkg::SRC_LETTER;
        if (can_load) begin
          cmd.load   = 1'b1;
          state_next = lcsr_pkg::ST_LEVEL;
        end
      end
      lcsr_pkg::ST_LEVEL: begin
        cmd.sel  = lcsr_pkg::SRC_LEVEL;
        cmd.last = !status.more_changes;
        if (can_load) begin
          cmd.load   = 1'b1;
          state_next = status.more_changes ? lcsr_pkg::ST_LETTER : lcsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lcsr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/lcsr_datapath.sv
// ----------------------------------------------------------------------------
// lcsr_datapath
// Panel state, switch change tracking and the output register.
// ----------------------------------------------------------------------------
module lcsr_datapath #(
  parameter int NUM_SWITCHES = 13,
  parameter int NUM_DIGITS   = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [23:0]           s_tdata,
  input  logic [1:0]            s_tuser,
  output logic [31:0]           m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast,
  input  lcsr_pkg::ctrl_cmd_t   cmd,
  output lcsr_pkg::dp_status_t  status
);

  localparam int WORDS = NUM_DIGITS + 1;
  localparam int WPW   = $clog2(NUM_DIGITS + 1);
  localparam int SPW   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int IDXW  = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

  logic [1:0]              in_cmd;
  logic [7:0]              in_byte;
  logic [NUM_SWITCHES-1:0] in_sw;

  logic                    link_up;
  logic [WPW-1:0]          word_pointer;
  logic [7:0]              display_words [WORDS];
  logic [NUM_SWITCHES-1:0] previous_switches;
  logic [SPW-1:0]          scan_position;

  logic [NUM_SWITCHES-1:0] diff_bits;
  logic [NUM_SWITCHES-1:0] level_bits;
  logic [SPW-1:0]          drive_pos;

  logic [NUM_SWITCHES-1:0] scan_diff;
  logic [NUM_SWITCHES-1:0] low_bit;
  logic [IDXW-1:0]         low_idx;
  logic [7:0]              up_offset;
  logic [7:0]              low_offset;
  logic [7:0]              digit_offset;
  logic                    is_digit_sel;
  logic                    is_set;
  logic                    is_clear;

  logic [7:0]              reply_byte;
  logic                    reply_valid;
  logic                    run_last;
  logic [7:0]              segment_pattern;
  logic [3:0]              digit_enable;
  logic [7:0]              led_pattern;
  logic [7:0]              byte_sel;

  assign in_cmd  = s_tuser;
  assign in_byte = s_tdata[7:0];
  assign in_sw   = s_tdata[8 +: NUM_SWITCHES];

  assign up_offset    = in_byte - lcsr_pkg::CHAR_A_UP;
  assign low_offset   = in_byte - lcsr_pkg::CHAR_A_LOW;
  assign digit_offset = in_byte - lcsr_pkg::CHAR_0;
  assign is_digit_sel = (in_byte >= lcsr_pkg::CHAR_0) &&
                        (in_byte <= lcsr_pkg::CHAR_0 + 8'(NUM_DIGITS));
  assign is_set       = (in_byte >= lcsr_pkg::CHAR_A_UP) && (in_byte <= lcsr_pkg::CHAR_H_UP);
  assign is_clear     = (in_byte >= lcsr_pkg::CHAR_A_LOW) && (in_byte <= lcsr_pkg::CHAR_H_LOW);

  assign scan_diff = previous_switches ^ in_sw;

  // Lowest pending change is reported first.
  assign low_bit = diff_bits & (~diff_bits + NUM_SWITCHES'(1));

  always_comb begin
    low_idx = '0;
    for (int i = NUM_SWITCHES - 1; i >= 0; i--) begin
      if (diff_bits[i]) begin
        low_idx = IDXW'(i);
      end
    end
  end

  assign status.is_connect   = (in_cmd == lcsr_pkg::CMD_HOST) && (in_byte == lcsr_pkg::CHAR_X);
  assign status.has_changes  = (in_cmd == lcsr_pkg::CMD_SCAN) && link_up && (scan_diff != '0);
  assign status.more_changes = ((diff_bits & ~low_bit) != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      link_up           <= 1'b0;
      word_pointer      <= '0;
      previous_switches <= '0;
      scan_position     <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        display_words[i] <= lcsr_pkg::DIGIT_RESET;
      end
      display_words[NUM_DIGITS] <= 8'h00;
    end else if (cmd.accept) begin
      case (in_cmd)
        lcsr_pkg::CMD_HOST: begin
          if (in_byte == lcsr_pkg::CHAR_X) begin
            link_up <= 1'b1;
          end else if (link_up) begin
            if (in_byte == lcsr_pkg::CHAR_Z) begin
              previous_switches <= in_sw ^ lcsr_pkg::RESEND_MASK[NUM_SWITCHES-1:0];
              for (int i = 0; i < WORDS; i++) begin
                display_words[i] <= 8'h00;
              end
            end else if (is_digit_sel) begin
              word_pointer <= digit_offset[WPW-1:0];
            end else if (is_set || is_clear) begin
              // Each word updates itself when the pointer selects it.
              for (int i = 0; i < WORDS; i++) begin
                if (word_pointer == WPW'(i)) begin
                  if (is_set) begin
                    display_words[i][up_offset[2:0]] <= 1'b1;
                  end else begin
                    display_words[i][low_offset[2:0]] <= 1'b0;
                  end
                end
              end
            end
          end
        end
        lcsr_pkg::CMD_SCAN: begin
          if (link_up) begin
            previous_switches <= in_sw;
          end
        end
        lcsr_pkg::CMD_TICK: begin
          if (scan_position == SPW'(NUM_DIGITS - 1)) begin
            scan_position <= '0;
          end else begin
            scan_position <= scan_position + SPW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Per-item working registers. A tick drives the digit from before it advances.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      drive_pos  <= scan_position;
      diff_bits  <= scan_diff;
      level_bits <= in_sw;
    end else if (cmd.load && (cmd.sel == lcsr_pkg::SRC_LEVEL)) begin
      diff_bits <= diff_bits & ~low_bit;
    end
  end

  always_comb begin
    case (cmd.sel)
      lcsr_pkg::SRC_W:      byte_sel = lcsr_pkg::CHAR_W;
      lcsr_pkg::SRC_Y:      byte_sel = lcsr_pkg::CHAR_Y;
      lcsr_pkg::SRC_LETTER: byte_sel = lcsr_pkg::change_letter(4'(low_idx));
      lcsr_pkg::SRC_LEVEL:  byte_sel = level_bits[low_idx] ? lcsr_pkg::CHAR_U_UP
                                                           : lcsr_pkg::CHAR_U_LOW;
      default:              byte_sel = 8'h00;
    endcase
  end

  // Output register; the panel view is captured with every transfer.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      reply_byte      <= byte_sel;
      reply_valid     <= (cmd.sel != lcsr_pkg::SRC_NONE);
      run_last        <= cmd.last;
      segment_pattern <= display_words[WPW'(drive_pos)];
      digit_enable    <= (int'(drive_pos) < 4) ? (4'b0001 << drive_pos) : 4'b0000;
      led_pattern     <= display_words[NUM_DIGITS];
    end
  end

  assign m_tdata = {4'b0000, led_pattern, digit_enable, segment_pattern, reply_byte};
  assign m_tuser = reply_valid;
  assign m_tlast = run_last;

endmodule

>>> src/lcsr_checker.sv
// ----------------------------------------------------------------------------
// lcsr_checker
// Port-level checks of the reporter's output stream.
// ----------------------------------------------------------------------------
module lcsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A held result keeps its whole payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("output changed while stalled");

  // A result without a reply byte is always alone in its run and carries zero.
  a_noreply: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'h00))
    else $error("empty result is not a lone zero result");

  a_digit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[19:16]))
    else $error("digit enable is not one-hot");

  // Only one item is in work at a time.
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind led_command_switch_reporter_core lcsr_checker u_lcsr_checker (.*);
